### rtl/smx_pkg.sv
// Shared widths, format codes and stage-enable types for the stereo frame mixer.
package smx_pkg;

  localparam int MODE_W = 2;
  localparam int SAMP_W = 32;
  localparam int MIX_W  = 16;
  localparam int SRC_W  = 32;
  localparam int MAG_W  = 39;
  localparam int NSTAGE = 5;

  localparam logic [MODE_W-1:0] MODE_U8  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_S16 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_F32 = 2'd2;

  // 1/sqrt(2) as an unsigned 32-bit fraction.
  localparam logic [31:0] MIX_K = 32'd3037000500;

  typedef struct packed {
    logic ld1;
    logic ld2;
  } conv_en_t;

  typedef struct packed {
    logic lda;
    logic ldb;
    logic ldc;
  } scale_en_t;

endpackage

### rtl/saturating_stereo_frame_mixer.sv
// Each accepted input beat passes through every register stage before its output beat is valid.
// Throughput: one beat per cycle; five register stages (two of sample conversion,
// then sum, 32x32 multiply and clamp) each hold a valid bit and load when empty or
// when the next stage moves, so bubbles are squeezed out and a waiting output blocks
// new input only once all five stages are full.
// Reset clears the valid bits only; the data path registers are not reset.
module saturating_stereo_frame_mixer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [smx_pkg::MODE_W-1:0]  mode,
  input  logic                               stereo,
  input  logic        [smx_pkg::SAMP_W-1:0]  left_sample,
  input  logic        [smx_pkg::SAMP_W-1:0]  right_sample,
  input  logic signed [smx_pkg::MIX_W-1:0]   mix_left,
  input  logic signed [smx_pkg::MIX_W-1:0]   mix_right,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [smx_pkg::MIX_W-1:0]   out_left,
  output logic signed [smx_pkg::MIX_W-1:0]   out_right
);
  import smx_pkg::*;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] rdy;
  conv_en_t          cen;
  scale_en_t         sen;
  logic [SAMP_W-1:0] rsel;

  logic signed [SRC_W-1:0] src_l;
  logic signed [SRC_W-1:0] src_r;
  logic signed [MIX_W-1:0] mixd_l;
  logic signed [MIX_W-1:0] mixd_r;

  // A stage may load when it is empty or the stage after it is loading too.
  always_comb begin
    rdy[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NSTAGE-1];

  assign cen = '{ld1: rdy[0], ld2: rdy[1]};
  assign sen = '{lda: rdy[2], ldb: rdy[3], ldc: rdy[4]};

  // In mono the left sample feeds both channels.
  assign rsel = stereo ? right_sample : left_sample;

  smx_conv u_conv_l (
    .clk     (clk),
    .en      (cen),
    .mode    (mode),
    .sample  (left_sample),
    .mix     (mix_left),
    .src     (src_l),
    .mix_out (mixd_l)
  );

  smx_conv u_conv_r (
    .clk     (clk),
    .en      (cen),
    .mode    (mode),
    .sample  (rsel),
    .mix     (mix_right),
    .src     (src_r),
    .mix_out (mixd_r)
  );

  smx_scale u_scale_l (
    .clk (clk),
    .en  (sen),
    .src (src_l),
    .mix (mixd_l),
    .res (out_left)
  );

  smx_scale u_scale_r (
    .clk (clk),
    .en  (sen),
    .src (src_r),
    .mix (mixd_r),
    .res (out_right)
  );

endmodule

### rtl/smx_conv.sv
// Two-stage conversion of one raw sample to a 16-bit-scaled integer.
module smx_conv (
  input  logic                                clk,
  input  smx_pkg::conv_en_t                   en,
  input  logic        [smx_pkg::MODE_W-1:0]   mode,
  input  logic        [smx_pkg::SAMP_W-1:0]   sample,
  input  logic signed [smx_pkg::MIX_W-1:0]    mix,
  output logic signed [smx_pkg::SRC_W-1:0]    src,
  output logic signed [smx_pkg::MIX_W-1:0]    mix_out
);
  import smx_pkg::*;

  logic [7:0]        ex;
  logic [22:0]       fr;
  logic [23:0]       man;
  logic [MAG_W-1:0]  mag_next;
  logic [7:0]        shamt_next;
  logic              fsat_next;
  logic              fnan_next;
  logic signed [8:0] d;
  logic signed [SRC_W-1:0] u8val;
  logic signed [SRC_W-1:0] dval_next;

  logic [MODE_W-1:0]       mode_q;
  logic signed [SRC_W-1:0] dval_q;
  logic [MAG_W-1:0]        mag_q;
  logic [7:0]              shamt_q;
  logic                    neg_q;
  logic                    fsat_q;
  logic                    fnan_q;
  logic signed [MIX_W-1:0] mix_q;

  logic [MAG_W-1:0]        shifted;
  logic [MAG_W-1:0]        limit;
  logic [MAG_W-1:0]        q;
  logic [SRC_W-1:0]        q32;
  logic [SRC_W-1:0]        fval;
  logic signed [SRC_W-1:0] src_next;

  always_comb begin
    ex  = sample[30:23];
    fr  = sample[22:0];
    man = {(ex != 8'd0), fr};
    // Mantissa times 32767 without a multiplier.
    mag_next = {man, 15'd0} - {15'd0, man};
    if (ex == 8'd0) begin
      shamt_next = 8'd149;
    end else begin
      shamt_next = 8'd150 - ex;
    end
    fnan_next = (ex == 8'hFF) && (fr != 23'd0);
    fsat_next = (ex == 8'hFF) ? (fr == 23'd0) : (ex >= 8'd150);

    // 32767/127 is 258 remainder 1, so only the extreme codes need a correction.
    d     = $signed({1'b0, sample[7:0]}) - 9'sd128;
    u8val = (SRC_W'(d) <<< 8) + (SRC_W'(d) <<< 1);
    if (d == 9'sd127) begin
      u8val = u8val + 32'sd1;
    end else if (d == -9'sd128 || d == -9'sd127) begin
      u8val = u8val - 32'sd1;
    end

    unique case (mode)
      MODE_U8:  dval_next = u8val;
      MODE_S16: dval_next = SRC_W'($signed(sample[15:0]));
      default:  dval_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      mode_q  <= mode;
      dval_q  <= dval_next;
      mag_q   <= mag_next;
      shamt_q <= shamt_next;
      neg_q   <= sample[31];
      fsat_q  <= fsat_next;
      fnan_q  <= fnan_next;
      mix_q   <= mix;
    end
  end

  always_comb begin
    shifted = mag_q >> shamt_q;
    limit   = neg_q ? MAG_W'(33'h080000000) : MAG_W'(33'h07FFFFFFF);
    if (fsat_q || (shifted > limit)) begin
      q = limit;
    end else begin
      q = shifted;
    end
    q32 = q[SRC_W-1:0];
    if (fnan_q) begin
      fval = '0;
    end else if (neg_q) begin
      fval = ~q32 + 32'd1;
    end else begin
      fval = q32;
    end
    src_next = (mode_q == MODE_F32) ? $signed(fval) : dval_q;
  end

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      src     <= src_next;
      mix_out <= mix_q;
    end
  end

endmodule

### rtl/smx_scale.sv
// Three-stage sum, scale by 1/sqrt(2) and clamp to int16 for one channel.
module smx_scale (
  input  logic                              clk,
  input  smx_pkg::scale_en_t                en,
  input  logic signed [smx_pkg::SRC_W-1:0]  src,
  input  logic signed [smx_pkg::MIX_W-1:0]  mix,
  output logic signed [smx_pkg::MIX_W-1:0]  res
);
  import smx_pkg::*;

  logic signed [SRC_W:0] sum;
  logic [SRC_W:0]        absv;
  logic [SRC_W-1:0]      a_q;
  logic                  nega_q;
  logic [63:0]           prod;
  logic [31:0]           p_q;
  logic                  negb_q;
  logic signed [MIX_W-1:0] res_next;

  always_comb begin
    sum  = {src[SRC_W-1], src} + (SRC_W+1)'(mix);
    absv = sum[SRC_W] ? (~sum + 1'b1) : sum;
  end

  // The magnitude never exceeds 2^31 + 32768, so 32 bits hold it.
  always_ff @(posedge clk) begin
    if (en.lda) begin
      a_q    <= absv[SRC_W-1:0];
      nega_q <= sum[SRC_W];
    end
  end

  assign prod = {32'd0, a_q} * {32'd0, MIX_K};

  always_ff @(posedge clk) begin
    if (en.ldb) begin
      p_q    <= prod[63:32];
      negb_q <= nega_q;
    end
  end

  always_comb begin
    if (negb_q) begin
      res_next = (p_q > 32'd32768) ? -16'sd32768 : $signed(16'(~p_q[15:0] + 16'd1));
    end else begin
      res_next = (p_q > 32'd32767) ? 16'sd32767 : $signed(p_q[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.ldc) begin
      res <= res_next;
    end
  end

endmodule

### rtl/smx_check.sv
// Port-level checks for the stereo frame mixer, bound to the top level.
module smx_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [smx_pkg::MIX_W-1:0]  out_left,
  input logic signed [smx_pkg::MIX_W-1:0]  out_right
);
  import smx_pkg::*;

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("output beat changed while stalled");

  // Nothing comes out straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // With the output stage empty the whole pipeline can move.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

  // An accepted beat reaches the output when the sink stays ready while it moves through the stages.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      ##1 out_ready |=> out_valid)
    else $error("beat did not arrive within the pipeline latency");

endmodule

bind saturating_stereo_frame_mixer smx_check u_smx_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_left  (out_left),
  .out_right (out_right)
);

### bench/tb_saturating_stereo_frame_mixer.sv
// Self-checking testbench for the saturating stereo frame mixer.
module tb_saturating_stereo_frame_mixer;

  localparam logic [smx_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
  // 1/sqrt(2) as an unsigned 32-bit fraction.
  localparam logic [31:0] ATTEN_K = 32'd3037000500;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_FRAMES = 400;
  localparam int HOLD_AFTER = 120;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [smx_pkg::MODE_W-1:0]        mode;
    logic                              stereo;
    logic [smx_pkg::SAMP_W-1:0]        left;
    logic [smx_pkg::SAMP_W-1:0]        right;
    logic signed [smx_pkg::MIX_W-1:0]  mix_l;
    logic signed [smx_pkg::MIX_W-1:0]  mix_r;
    int                                gap;
  } frame_t;

  typedef struct packed {
    logic signed [smx_pkg::MIX_W-1:0] left;
    logic signed [smx_pkg::MIX_W-1:0] right;
  } mix_pair_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [smx_pkg::MODE_W-1:0] mode = '0;
  logic stereo = 1'b0;
  logic [smx_pkg::SAMP_W-1:0] left_sample = '0;
  logic [smx_pkg::SAMP_W-1:0] right_sample = '0;
  logic signed [smx_pkg::MIX_W-1:0] mix_left = '0;
  logic signed [smx_pkg::MIX_W-1:0] mix_right = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [smx_pkg::MIX_W-1:0] out_left;
  logic signed [smx_pkg::MIX_W-1:0] out_right;

  frame_t frames_pending[$];
  mix_pair_t mixes_due[$];
  logic in_beat_taken = 1'b0;
  logic out_beat_taken = 1'b0;
  int cycle_count = 0;
  int mismatches = 0;
  int results_taken = 0;
  int tx_calm = 0;
  int tx_wait = 0;
  bit gap_armed = 1'b0;
  int rx_calm = 0;
  int rx_wait = 0;
  bit long_hold_done = 1'b0;

  saturating_stereo_frame_mixer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .stereo       (stereo),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .mix_left     (mix_left),
    .mix_right    (mix_right),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left     (out_left),
    .out_right    (out_right)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Float bits times 32767, truncated toward zero and saturated to 32 bits, done exactly.
  function automatic longint float_bits_to_scaled(logic [31:0] raw);
    logic [7:0] ex;
    logic [22:0] fr;
    logic neg;
    longint unsigned lim;
    longint unsigned m;
    longint unsigned mag;
    longint unsigned q;
    int sh;
    ex = raw[30:23];
    fr = raw[22:0];
    neg = raw[31];
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (ex == 8'hFF) begin
      if (fr != 0) return 0;
      q = lim;
    end else begin
      m = (ex != 0) ? {40'd0, 1'b1, fr} : {41'd0, fr};
      sh = (ex != 0) ? int'(ex) - 150 : -149;
      mag = m * 64'd32767;
      if (sh >= 0) begin
        q = (mag == 0) ? 64'd0 : lim;
      end else begin
        q = (-sh >= 64) ? 64'd0 : (mag >> (-sh));
        if (q > lim) q = lim;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint scale_sample(logic [smx_pkg::MODE_W-1:0] md, logic [31:0] raw);
    longint d;
    logic signed [15:0] s;
    case (md)
      smx_pkg::MODE_U8: begin
        d = longint'({56'd0, raw[7:0]}) - 128;
        return (d * 32767) / 127;
      end
      smx_pkg::MODE_S16: begin
        s = raw[15:0];
        return s;
      end
      smx_pkg::MODE_F32: return float_bits_to_scaled(raw);
      default: return 0;
    endcase
  endfunction

  // The product is formed on the magnitude, so truncation is toward zero.
  function automatic logic signed [15:0] attenuate_and_clamp(longint src,
                                                             logic signed [15:0] mix);
    longint sum;
    logic neg;
    logic [95:0] mag;
    logic [95:0] p;
    longint lp;
    longint r;
    sum = src + longint'(mix);
    neg = sum < 0;
    mag = neg ? 96'(-sum) : 96'(sum);
    p = (mag * 96'(ATTEN_K)) >> 32;
    lp = longint'(p[63:0]);
    if (neg) r = (lp > 32768) ? -32768 : -lp;
    else r = (lp > 32767) ? 32767 : lp;
    return 16'(r);
  endfunction

  function automatic mix_pair_t mix_frame(logic [smx_pkg::MODE_W-1:0] md, logic st,
                                          logic [31:0] l, logic [31:0] r,
                                          logic signed [15:0] ml, logic signed [15:0] mr);
    mix_pair_t res;
    longint sl;
    longint sr;
    sl = scale_sample(md, l);
    sr = st ? scale_sample(md, r) : sl;
    res.left = attenuate_and_clamp(sl, ml);
    res.right = attenuate_and_clamp(sr, mr);
    return res;
  endfunction

  // Idle length for one beat, with occasional stretches of back-to-back traffic.
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [31:0] random_sample(logic [smx_pkg::MODE_W-1:0] md);
    if (md == smx_pkg::MODE_F32 && $urandom_range(0, 3) != 0)
      return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 160)), 23'($urandom)};
    return $urandom;
  endfunction

  function automatic logic signed [15:0] random_mix();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_frame(logic [smx_pkg::MODE_W-1:0] md, logic st,
                           logic [31:0] l, logic [31:0] r,
                           logic signed [15:0] ml, logic signed [15:0] mr);
    frame_t f;
    f.mode = md;
    f.stereo = st;
    f.left = l;
    f.right = r;
    f.mix_l = ml;
    f.mix_r = mr;
    f.gap = pick_wait(tx_calm);
    frames_pending.push_back(f);
  endtask

  // Sender: presents the next frame after its drawn gap, holding it until the beat is taken.
  always @(negedge clk) begin : frame_sender
    logic nv;
    frame_t cur;
    nv = in_valid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_beat_taken) nv = 1'b0;
      if (!nv && frames_pending.size() != 0) begin
        if (!gap_armed) begin
          tx_wait = frames_pending[0].gap;
          gap_armed = 1'b1;
        end
        if (tx_wait > 0) begin
          tx_wait--;
        end else begin
          cur = frames_pending.pop_front();
          gap_armed = 1'b0;
          mode <= cur.mode;
          stereo <= cur.stereo;
          left_sample <= cur.left;
          right_sample <= cur.right;
          mix_left <= cur.mix_l;
          mix_right <= cur.mix_r;
          nv = 1'b1;
        end
      end
    end
    in_valid <= nv;
  end

  // Receiver: stalls at random between beats, and once for a long stretch so that
  // the pipeline fills and pushes back on the sender.
  always @(negedge clk) begin : mix_receiver
    logic nr;
    nr = out_ready;
    if (rst) begin
      nr = 1'b0;
    end else begin
      if (out_ready && out_beat_taken) begin
        nr = 1'b0;
        if (!long_hold_done && results_taken >= HOLD_AFTER) begin
          rx_wait = HOLD_CYCLES;
          long_hold_done = 1'b1;
        end else begin
          rx_wait = pick_wait(rx_calm);
        end
      end
      if (!nr) begin
        if (rx_wait > 0) rx_wait--;
        else nr = 1'b1;
      end
    end
    out_ready <= nr;
  end

  always @(posedge clk) begin : mix_checker
    mix_pair_t want;
    cycle_count <= cycle_count + 1;
    in_beat_taken <= !rst && in_valid && in_ready;
    out_beat_taken <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      results_taken <= results_taken + 1;
      if (mixes_due.size() == 0) begin
        $error("output beat with no frame outstanding: out_left %0d, out_right %0d",
               out_left, out_right);
        mismatches++;
      end else begin
        want = mixes_due.pop_front();
        if (out_left !== want.left) begin
          $error("out_left: expected %0d, got %0d", $signed(want.left), out_left);
          mismatches++;
        end
        if (out_right !== want.right) begin
          $error("out_right: expected %0d, got %0d", $signed(want.right), out_right);
          mismatches++;
        end
      end
    end
    if (!rst && in_valid && in_ready)
      mixes_due.push_back(mix_frame(mode, stereo, left_sample, right_sample,
                                    mix_left, mix_right));
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : run
    logic [smx_pkg::MODE_W-1:0] md;
    // Format extremes, mono and stereo, full-scale mixes.
    add_frame(smx_pkg::MODE_U8, 1'b1, 32'h0000_0000, 32'h0000_00FF, 16'sd0, 16'sd0);
    add_frame(smx_pkg::MODE_U8, 1'b0, 32'hFFFF_FF80, 32'h0000_0011, 16'sh7FFF, 16'sh8000);
    add_frame(smx_pkg::MODE_U8, 1'b1, 32'h1234_56FF, 32'hFFFF_FF00, 16'sh8000, 16'sh8000);
    add_frame(smx_pkg::MODE_U8, 1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF);
    add_frame(smx_pkg::MODE_S16, 1'b1, 32'h0000_8000, 32'h0000_7FFF, 16'sh8000, 16'sh7FFF);
    add_frame(smx_pkg::MODE_S16, 1'b0, 32'hABCD_0000, 32'h1234_FFFF, 16'sd100, -16'sd100);
    add_frame(smx_pkg::MODE_S16, 1'b1, 32'hFFFF_7FFF, 32'h5555_8000, 16'sh7FFF, 16'sh8000);
    // Infinities saturate, NaN gives zero.
    add_frame(smx_pkg::MODE_F32, 1'b1, 32'h7F80_0000, 32'hFF80_0000, 16'sd0, 16'sd0);
    add_frame(smx_pkg::MODE_F32, 1'b1, 32'h7FC0_0001, 32'hFFFF_FFFF, 16'sd1234, -16'sd5);
    // Subnormals and tiny values truncate to zero; normal, signed-zero and large values follow.
    add_frame(smx_pkg::MODE_F32, 1'b1, 32'h0000_0001, 32'h807F_FFFF, 16'sd7, -16'sd7);
    add_frame(smx_pkg::MODE_F32, 1'b1, 32'h3F80_0000, 32'hBF80_0000, 16'sd0, 16'sd0);
    add_frame(smx_pkg::MODE_F32, 1'b1, 32'h3F00_0000, 32'h3300_0000, -16'sd1, 16'sd1);
    add_frame(smx_pkg::MODE_F32, 1'b1, 32'h4F00_0000, 32'hCF00_0000, 16'sh7FFF, 16'sh8000);
    add_frame(smx_pkg::MODE_F32, 1'b1, 32'h0000_0000, 32'h8000_0000, 16'sd0, 16'sd0);
    add_frame(smx_pkg::MODE_F32, 1'b0, 32'h477F_FF00, 32'h7F80_0000, 16'sh8000, 16'sd0);
    add_frame(smx_pkg::MODE_F32, 1'b1, 32'h4E80_0000, 32'hB780_0000, 16'sd0, 16'sd0);
    add_frame(smx_pkg::MODE_F32, 1'b0, 32'hBF7F_FFFF, 32'h3F80_0000, 16'sd3, 16'sd3);
    // The unused format contributes nothing, leaving only the scaled mix.
    add_frame(MODE_NONE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000);
    add_frame(MODE_NONE, 1'b0, 32'h7F80_0000, 32'h0000_0000, 16'shFFFF, 16'sd1);
    add_frame(smx_pkg::MODE_U8, 1'b0, 32'h0000_007F, 32'h0000_0080, -16'sd32767, 16'sd32766);
    for (int i = 0; i < RANDOM_FRAMES; i++) begin
      md = ($urandom_range(0, 9) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
      add_frame(md, 1'($urandom_range(0, 1)), random_sample(md), random_sample(md),
                random_mix(), random_mix());
    end

    @(negedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (frames_pending.size() != 0 || in_valid) @(posedge clk);
    while (mixes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/smx_pkg.sv
rtl/smx_conv.sv
rtl/smx_scale.sv
rtl/saturating_stereo_frame_mixer.sv
rtl/smx_check.sv
bench/tb_saturating_stereo_frame_mixer.sv
